[hw/rtl/fas_pkg.sv]
// Package with types and constants shared by the truncating float adder.
package fas_pkg;

   localparam int unsigned MantWidth = 24;
   localparam int unsigned WorkWidth = 28;
   localparam logic [31:0] MaxFinite = 32'h7F7F_FFFF;

   typedef enum logic {
      OP_ADD = 1'b0,
      OP_SUB = 1'b1
   } op_type;

   // Aligned operands after the first stage.
   typedef struct packed {
      logic                 zero_out;
      logic                 sign_zero;
      logic                 sign_big;
      logic                 eff_sub;
      logic [8:0]           exp_big;
      logic [WorkWidth-1:0] big_mag;
      logic [WorkWidth-1:0] small_mag;
   } align_type;

   // Raw sum after the second stage.
   typedef struct packed {
      logic                 zero_out;
      logic                 sign_zero;
      logic                 sign_big;
      logic                 eff_sub;
      logic [8:0]           exp_big;
      logic [WorkWidth-1:0] sum;
   } sum_type;

   // Normalised result ahead of packing.
   typedef struct packed {
      logic        zero_out;
      logic        sign_zero;
      logic        sign_big;
      logic        cancel;
      logic signed [10:0] exp_norm;
      logic [22:0] frac;
   } norm_type;

endpackage

[hw/rtl/float_add_sub_truncating.sv]
// Pipelined single-precision adder and subtractor rounding toward zero.
// A request passes the registers s1_ff, s2_ff, s3_ff and out_ff before its result is valid.
// Throughput: one request per cycle; a stall freezes the whole pipeline.
// Stages: unpack and align, add or subtract, normalise, pack into output.
// Reset clears the stage valid bits only; the datapath registers keep values.
module float_add_sub_truncating (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_first_operand,
   input  logic [31:0] req_second_operand,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_sum_word
);

   localparam int unsigned WW = fas_pkg::WorkWidth;

   fas_pkg::align_type s1_ff, s1_in;
   fas_pkg::sum_type   s2_ff, s2_in;
   fas_pkg::norm_type  s3_ff, s3_in;
   logic [31:0]        out_ff, out_in;
   logic [3:0]         vld_ff;
   logic               adv;

   // The whole pipeline moves unless a finished result is held back.
   assign adv       = !(vld_ff[3] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[3];
   assign rsp_sum_word = out_ff;

   // Stage one: unpack, order by magnitude and align the smaller operand.
   always_comb begin
      logic        sa, sb, a_big;
      logic [7:0]  ea, eb, eb_big, es;
      logic [23:0] ma, mb, mbg, msm;
      logic [7:0]  d;
      logic [WW-1:0] sm, lostmask;
      sa = req_first_operand[31];
      sb = req_second_operand[31] ^ (fas_pkg::op_type'(req_op) == fas_pkg::OP_SUB);
      ea = req_first_operand[30:23];
      eb = req_second_operand[30:23];
      ma = (ea == 8'd0) ? 24'd0 : {1'b1, req_first_operand[22:0]};
      mb = (eb == 8'd0) ? 24'd0 : {1'b1, req_second_operand[22:0]};
      a_big = (ea > eb) || ((ea == eb) && (ma >= mb));
      eb_big = a_big ? ea : eb;
      es  = a_big ? eb : ea;
      mbg = a_big ? ma : mb;
      msm = a_big ? mb : ma;
      d = eb_big - es;
      sm = {1'b0, msm, 3'b000};
      lostmask = '0;
      if (msm != 24'd0) begin
         if (d >= 8'd27) begin
            sm = WW'(1);
         end else begin
            lostmask = (WW'(1) << d[4:0]) - WW'(1);
            sm = (sm >> d[4:0]) | WW'((sm & lostmask) != '0);
         end
      end
      s1_in.zero_out  = (ma == 24'd0) && (mb == 24'd0);
      s1_in.sign_zero = sa & sb;
      s1_in.sign_big  = a_big ? sa : sb;
      s1_in.eff_sub   = sa ^ sb;
      s1_in.exp_big   = {1'b0, eb_big};
      s1_in.big_mag   = {1'b0, mbg, 3'b000};
      s1_in.small_mag = sm;
   end

   // Stage two: add or subtract the aligned magnitudes.
   always_comb begin
      s2_in.zero_out  = s1_ff.zero_out;
      s2_in.sign_zero = s1_ff.sign_zero;
      s2_in.sign_big  = s1_ff.sign_big;
      s2_in.eff_sub   = s1_ff.eff_sub;
      s2_in.exp_big   = s1_ff.exp_big;
      s2_in.sum = s1_ff.eff_sub ? (s1_ff.big_mag - s1_ff.small_mag)
                                : (s1_ff.big_mag + s1_ff.small_mag);
   end

   // Stage three: normalise with a leading-one search and adjust the exponent.
   always_comb begin
      logic [4:0]    lz;
      logic [WW-1:0] r;
      lz = 5'd0;
      for (int i = 0; i < 27; i++) begin
         if (s2_ff.sum[i]) lz = 5'(26 - i);
      end
      r = s2_ff.sum;
      s3_in.exp_norm = 11'(s2_ff.exp_big);
      if (s2_ff.sum[WW-1]) begin
         r = (s2_ff.sum >> 1) | WW'(s2_ff.sum[0]);
         s3_in.exp_norm = 11'(s2_ff.exp_big) + 11'sd1;
      end else if (s2_ff.eff_sub) begin
         r = s2_ff.sum << lz;
         s3_in.exp_norm = 11'(s2_ff.exp_big) - 11'(lz);
      end
      s3_in.zero_out  = s2_ff.zero_out;
      s3_in.sign_zero = s2_ff.sign_zero;
      s3_in.sign_big  = s2_ff.sign_big;
      s3_in.cancel    = s2_ff.eff_sub && (s2_ff.sum == '0);
      s3_in.frac      = r[25:3];
   end

   // Stage four: special cases and packing.
   always_comb begin
      priority if (s3_ff.zero_out) begin
         out_in = {s3_ff.sign_zero, 31'd0};
      end else if (s3_ff.cancel) begin
         out_in = 32'd0;
      end else if (s3_ff.exp_norm <= 11'sd0) begin
         out_in = {s3_ff.sign_big, 31'd0};
      end else if (s3_ff.exp_norm >= 11'sd255) begin
         out_in = {s3_ff.sign_big, 31'd0} | fas_pkg::MaxFinite;
      end else begin
         out_in = {s3_ff.sign_big, s3_ff.exp_norm[7:0], s3_ff.frac};
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], req_valid};
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         out_ff <= out_in;
      end
   end

   // A held result must stay put.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sum_word))
      else $error("result changed while stalled");

   // Stall follows only from the output register.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without cause");

   // An accepted request reaches the output when no stall holds the pipeline.
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall ##1 !req_stall ##1 !req_stall ##1 !req_stall
      |=> rsp_valid)
      else $error("request lost in pipeline");

endmodule
